/* design/event_coalescing_table_macros.svh */
// Assertion macros for the event coalescing table.
// Taken in by the top level only; no other dependencies.
`ifndef EVENT_COALESCING_TABLE_MACROS_SVH
`define EVENT_COALESCING_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ECT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ect_pkg.sv */
// Shared types and constants for the event coalescing table.
// No dependencies; imported by ect_unit and event_coalescing_table.
package ect_pkg;

  localparam int unsigned SLOTS_PER_SCOPE_DEF = 16;
  localparam int unsigned LANES_DEF           = 4;
  localparam int unsigned EVENT_BITS_DEF      = 32;
  localparam int unsigned ADDR_BITS_DEF       = 64;

  localparam int unsigned NUM_SCOPES = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned LCNT_W     = 3;
  localparam int unsigned FLOW_W     = 16;
  localparam int unsigned PEER_W     = 64;
  localparam int unsigned BITS_W     = 32;
  localparam int unsigned SCOPE_W    = 2;
  localparam int unsigned OSLOT_W    = 4;
  localparam int unsigned ISLOT_W    = 8;
  localparam int unsigned LANE_IN_W  = 4;
  localparam int unsigned CODE_W     = 5;

  localparam logic [SCOPE_W-1:0] SCOPE_OUT  = 2'd0;
  localparam logic [SCOPE_W-1:0] SCOPE_IN   = 2'd1;
  localparam logic [SCOPE_W-1:0] SCOPE_PEER = 2'd2;

  localparam logic MODE_RECORD   = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED    = 3'd0,
    REG_EVENT_MASK = 3'd1,
    REG_OUT_SLOTS  = 3'd2,
    REG_IN_SLOTS   = 3'd3,
    REG_PEER_SLOTS = 3'd4,
    REG_LANE_COUNT = 3'd5
  } cfg_reg_e;

  // Status from the entry unit back to the sequencer.
  typedef struct packed {
    logic occupied;
    logic lane_hit;
  } ect_stat_t;

  // Clamp a slot or lane count to its limit.
  function automatic logic [CNT_W-1:0] sat_cnt(logic [CNT_W-1:0] n, int unsigned lim);
    logic [CNT_W-1:0] l;
    l = CNT_W'(lim);
    return (n > l) ? l : n;
  endfunction

endpackage

/* design/ect_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ect_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ect_unit.sv */
// Entry unit: merges an event into a table word and matches the owning lane.
// Depends on ect_pkg.
module ect_unit import ect_pkg::*; #(
  parameter int unsigned EVENT_BITS = EVENT_BITS_DEF,
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF,
  parameter int unsigned LANE_W     = 2
) (
  input  logic [LANE_W+FLOW_W+ADDR_BITS+EVENT_BITS-1:0] rdata_i,
  input  logic                                          occupied_i,
  input  logic [EVENT_BITS-1:0]                         ev_bit_i,
  input  logic [LANE_W-1:0]                             lane_i,
  input  logic [ADDR_BITS-1:0]                          peer_i,
  input  logic [FLOW_W-1:0]                             flow_i,
  output logic [LANE_W+FLOW_W+ADDR_BITS+EVENT_BITS-1:0] wdata_o,
  output ect_stat_t                                     stat_o
);

  localparam int unsigned WORD_W = LANE_W + FLOW_W + ADDR_BITS + EVENT_BITS;

  logic [LANE_W-1:0]     old_lane;
  logic [EVENT_BITS-1:0] old_bits;

  assign old_lane = rdata_i[WORD_W-1 -: LANE_W];
  assign old_bits = rdata_i[EVENT_BITS-1:0];

  // An occupied entry keeps its owner and handles; an empty one takes the new beat's.
  always_comb begin
    if (occupied_i) begin
      wdata_o = {rdata_i[WORD_W-1:EVENT_BITS], old_bits | ev_bit_i};
    end else begin
      wdata_o = {lane_i, flow_i, peer_i, ev_bit_i};
    end
  end

  assign stat_o.occupied = occupied_i;
  assign stat_o.lane_hit = occupied_i && (old_lane == lane_i);

endmodule

/* design/event_coalescing_table.sv */
// Event coalescing table: a rejected record or an empty dispatch gives its result in the
// cycle after start; an accepted record reads memory, then merges and writes back (S_REC).
// Dispatch walks the scopes in order and their slots one by one, reading each occupied slot
// in S_CHECK. busy drops as the last result goes out; results cannot be held off.
// Reset and every write to a defined configuration register clear all entries and lane
// counts at once.
`include "event_coalescing_table_macros.svh"

module event_coalescing_table import ect_pkg::*; #(
  parameter int unsigned SLOTS_PER_SCOPE = SLOTS_PER_SCOPE_DEF,
  parameter int unsigned LANES           = LANES_DEF,
  parameter int unsigned EVENT_BITS      = EVENT_BITS_DEF,
  parameter int unsigned ADDR_BITS       = ADDR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  mode_i,
  input  logic [SCOPE_W-1:0]    scope_i,
  input  logic [ISLOT_W-1:0]    slot_i,
  input  logic [LANE_IN_W-1:0]  lane_i,
  input  logic [CODE_W-1:0]     event_code_i,
  input  logic [PEER_W-1:0]     peer_addr_i,
  input  logic [FLOW_W-1:0]     flow_id_i,
  output logic                  res_valid_o,
  output logic                  accepted_o,
  output logic                  has_event_o,
  output logic [BITS_W-1:0]     event_bits_o,
  output logic [SCOPE_W-1:0]    event_scope_o,
  output logic [OSLOT_W-1:0]    event_slot_o,
  output logic [PEER_W-1:0]     event_peer_o,
  output logic [FLOW_W-1:0]     event_flow_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NENTRIES = NUM_SCOPES * SLOTS_PER_SCOPE;
  localparam int unsigned IDX_W    = $clog2(NENTRIES);
  localparam int unsigned LANE_W   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned PEND_W   = $clog2(NENTRIES + 1);
  localparam int unsigned SLOT_CW  = $clog2(SLOTS_PER_SCOPE + 1);
  localparam int unsigned WORD_W   = LANE_W + FLOW_W + ADDR_BITS + EVENT_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_REC   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_CHECK = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic                  enabled_q;
  logic [BITS_W-1:0]     mask_q;
  logic [CNT_W-1:0]      out_slots_q, in_slots_q, peer_slots_q;
  logic [LCNT_W-1:0]     lane_count_q;

  // Table occupancy and lane counts
  logic [NENTRIES-1:0]   valid_q, valid_d;
  logic [PEND_W-1:0]     pend_q [LANES];
  logic [PEND_W-1:0]     pend_d [LANES];

  // Item and walk state
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [EVENT_BITS-1:0] ev_bit_q, ev_bit_d;
  logic [ADDR_BITS-1:0]  peer_q, peer_d;
  logic [FLOW_W-1:0]     flow_q, flow_d;
  logic [LANE_W-1:0]     lane_q, lane_d;
  logic [PEND_W-1:0]     rem_q, rem_d;
  logic [SCOPE_W-1:0]    scan_scope_q, scan_scope_d;
  logic [SLOT_CW-1:0]    scan_slot_q, scan_slot_d;
  logic                  emitted_q, emitted_d;

  // Result register
  logic                  res_valid_q, res_valid_d;
  logic                  accepted_q, accepted_d;
  logic                  has_event_q, has_event_d;
  logic                  last_q, last_d;
  logic [BITS_W-1:0]     obits_q, obits_d;
  logic [SCOPE_W-1:0]    oscope_q, oscope_d;
  logic [OSLOT_W-1:0]    oslot_q, oslot_d;
  logic [PEER_W-1:0]     opeer_q, opeer_d;
  logic [FLOW_W-1:0]     oflow_q, oflow_d;

  // Memory and entry unit
  logic                  ram_re, ram_we;
  logic [IDX_W-1:0]      ram_raddr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;
  ect_stat_t             stat;

  // Decode
  logic                  active;
  logic [CNT_W-1:0]      lane_lim;
  logic [CNT_W-1:0]      eff_out, eff_in, eff_peer;
  logic [CNT_W-1:0]      in_eff, scan_eff;
  logic [SCOPE_W-1:0]    sc_in;
  logic                  code_ok, lane_ok, slot_ok, rec_ok, disp_ok;
  logic [IDX_W-1:0]      rec_idx, scan_idx;
  logic [EVENT_BITS-1:0] ev_bit_in;
  logic                  cfg_we, cfg_clear;

  assign busy        = (state_q != S_IDLE);
  // hold configuration off while an item is being taken
  assign cfg_ready_o = (state_q == S_IDLE) && !start;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    case (cfg_index_i)
      REG_ENABLED, REG_EVENT_MASK, REG_OUT_SLOTS,
      REG_IN_SLOTS, REG_PEER_SLOTS, REG_LANE_COUNT: cfg_clear = cfg_we;
      default: cfg_clear = 1'b0;
    endcase
  end

  assign active   = enabled_q && (|mask_q[EVENT_BITS-1:0]);
  assign lane_lim = active ? sat_cnt(CNT_W'(lane_count_q), LANES) : '0;
  assign eff_out  = active ? sat_cnt(out_slots_q, SLOTS_PER_SCOPE) : '0;
  assign eff_in   = active ? sat_cnt(in_slots_q, SLOTS_PER_SCOPE) : '0;
  assign eff_peer = active ? sat_cnt(peer_slots_q, SLOTS_PER_SCOPE) : '0;

  assign sc_in    = (scope_i > SCOPE_PEER) ? SCOPE_PEER : scope_i;
  assign in_eff   = (sc_in == SCOPE_OUT) ? eff_out : ((sc_in == SCOPE_IN) ? eff_in : eff_peer);
  assign scan_eff = (scan_scope_q == SCOPE_OUT) ? eff_out :
                    ((scan_scope_q == SCOPE_IN) ? eff_in : eff_peer);

  assign code_ok  = ((CODE_W + 1)'(event_code_i) < (CODE_W + 1)'(EVENT_BITS))
                    && mask_q[event_code_i];
  assign lane_ok  = CNT_W'(lane_i) < lane_lim;
  assign slot_ok  = slot_i < ISLOT_W'(in_eff);
  assign rec_ok   = active && code_ok && lane_ok && slot_ok;
  assign disp_ok  = lane_ok && (pend_q[LANE_W'(lane_i)] != '0);

  assign rec_idx  = IDX_W'(sc_in) * IDX_W'(SLOTS_PER_SCOPE) + IDX_W'(slot_i);
  assign scan_idx = IDX_W'(scan_scope_q) * IDX_W'(SLOTS_PER_SCOPE) + IDX_W'(scan_slot_q);
  assign ev_bit_in = EVENT_BITS'(1) << event_code_i;

  ect_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ect_unit #(
    .EVENT_BITS (EVENT_BITS),
    .ADDR_BITS  (ADDR_BITS),
    .LANE_W     (LANE_W)
  ) u_unit (
    .rdata_i    (ram_rdata),
    .occupied_i (valid_q[idx_q]),
    .ev_bit_i   (ev_bit_q),
    .lane_i     (lane_q),
    .peer_i     (peer_q),
    .flow_i     (flow_q),
    .wdata_o    (ram_wdata),
    .stat_o     (stat)
  );

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    pend_d       = pend_q;
    idx_d        = idx_q;
    ev_bit_d     = ev_bit_q;
    peer_d       = peer_q;
    flow_d       = flow_q;
    lane_d       = lane_q;
    rem_d        = rem_q;
    scan_scope_d = scan_scope_q;
    scan_slot_d  = scan_slot_q;
    emitted_d    = emitted_q;
    ram_re       = 1'b0;
    ram_raddr    = rec_idx;
    ram_we       = 1'b0;
    res_valid_d  = 1'b0;
    accepted_d   = 1'b0;
    has_event_d  = 1'b0;
    last_d       = 1'b0;
    obits_d      = '0;
    oscope_d     = '0;
    oslot_d      = '0;
    opeer_d      = '0;
    oflow_d      = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          lane_d = LANE_W'(lane_i);
          if (mode_i == MODE_RECORD && rec_ok) begin
            ram_re   = 1'b1;
            idx_d    = rec_idx;
            ev_bit_d = ev_bit_in;
            peer_d   = ADDR_BITS'(peer_addr_i);
            flow_d   = flow_id_i;
            state_d  = S_REC;
          end else if (mode_i == MODE_DISPATCH && disp_ok) begin
            rem_d        = pend_q[LANE_W'(lane_i)];
            scan_scope_d = SCOPE_OUT;
            scan_slot_d  = '0;
            emitted_d    = 1'b0;
            state_d      = S_SCAN;
          end else begin
            // rejected record or empty dispatch: one bare last beat
            res_valid_d = 1'b1;
            last_d      = 1'b1;
          end
        end
      end
      S_REC: begin
        ram_we         = 1'b1;
        valid_d[idx_q] = 1'b1;
        if (!stat.occupied && pend_q[lane_q] < PEND_W'(NENTRIES)) begin
          pend_d[lane_q] = pend_q[lane_q] + 1'b1;
        end
        res_valid_d = 1'b1;
        accepted_d  = 1'b1;
        last_d      = 1'b1;
        state_d     = S_IDLE;
      end
      S_SCAN: begin
        if (CNT_W'(scan_slot_q) < scan_eff) begin
          if (valid_q[scan_idx]) begin
            ram_re    = 1'b1;
            ram_raddr = scan_idx;
            idx_d     = scan_idx;
            state_d   = S_CHECK;
          end else begin
            scan_slot_d = scan_slot_q + 1'b1;
          end
        end else if (scan_scope_q == SCOPE_PEER) begin
          state_d = S_IDLE;
          if (!emitted_q) begin
            res_valid_d = 1'b1;
            last_d      = 1'b1;
          end
        end else begin
          scan_scope_d = scan_scope_q + 1'b1;
          scan_slot_d  = '0;
        end
      end
      S_CHECK: begin
        scan_slot_d = scan_slot_q + 1'b1;
        state_d     = S_SCAN;
        if (stat.lane_hit) begin
          res_valid_d    = 1'b1;
          has_event_d    = 1'b1;
          obits_d        = BITS_W'(ram_rdata[EVENT_BITS-1:0]);
          oscope_d       = scan_scope_q;
          oslot_d        = OSLOT_W'(scan_slot_q);
          opeer_d        = PEER_W'(ram_rdata[EVENT_BITS +: ADDR_BITS]);
          oflow_d        = ram_rdata[EVENT_BITS + ADDR_BITS +: FLOW_W];
          last_d         = (rem_q == PEND_W'(1));
          valid_d[idx_q] = 1'b0;
          if (pend_q[lane_q] != '0) begin
            pend_d[lane_q] = pend_q[lane_q] - 1'b1;
          end
          rem_d     = rem_q - 1'b1;
          emitted_d = 1'b1;
          // stop once the lane's count is reached
          if (rem_q == PEND_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_clear) begin
      valid_d = '0;
      for (int l = 0; l < LANES; l++) begin
        pend_d[l] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      enabled_q    <= 1'b0;
      mask_q       <= '0;
      out_slots_q  <= '0;
      in_slots_q   <= '0;
      peer_slots_q <= '0;
      lane_count_q <= '0;
      valid_q      <= '0;
      for (int l = 0; l < LANES; l++) begin
        pend_q[l] <= '0;
      end
      rem_q        <= '0;
      emitted_q    <= 1'b0;
      res_valid_q  <= 1'b0;
      accepted_q   <= 1'b0;
      has_event_q  <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      pend_q      <= pend_d;
      rem_q       <= rem_d;
      emitted_q   <= emitted_d;
      res_valid_q <= res_valid_d;
      accepted_q  <= accepted_d;
      has_event_q <= has_event_d;
      last_q      <= last_d;
      if (cfg_we) begin
        case (cfg_index_i)
          REG_ENABLED:    enabled_q    <= cfg_data_i[0];
          REG_EVENT_MASK: mask_q       <= cfg_data_i[BITS_W-1:0];
          REG_OUT_SLOTS:  out_slots_q  <= cfg_data_i[CNT_W-1:0];
          REG_IN_SLOTS:   in_slots_q   <= cfg_data_i[CNT_W-1:0];
          REG_PEER_SLOTS: peer_slots_q <= cfg_data_i[CNT_W-1:0];
          REG_LANE_COUNT: lane_count_q <= cfg_data_i[LCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    ev_bit_q     <= ev_bit_d;
    peer_q       <= peer_d;
    flow_q       <= flow_d;
    lane_q       <= lane_d;
    scan_scope_q <= scan_scope_d;
    scan_slot_q  <= scan_slot_d;
    obits_q      <= obits_d;
    oscope_q     <= oscope_d;
    oslot_q      <= oslot_d;
    opeer_q      <= opeer_d;
    oflow_q      <= oflow_d;
  end

  assign res_valid_o   = res_valid_q;
  assign accepted_o    = accepted_q;
  assign has_event_o   = has_event_q;
  assign last_o        = last_q;
  assign event_bits_o  = obits_q;
  assign event_scope_o = oscope_q;
  assign event_slot_o  = oslot_q;
  assign event_peer_o  = opeer_q;
  assign event_flow_o  = oflow_q;

  `ECT_ASSERT_IMPL(a_mid_beat_busy, clk_i, rst_ni, res_valid_o && !last_o, busy, "non-final dispatch beat while idle")
  `ECT_ASSERT_IMPL(a_record_beat, clk_i, rst_ni, accepted_o, res_valid_o && last_o && !has_event_o, "record beat malformed")
  `ECT_ASSERT_NEXT(a_cfg_clears, clk_i, rst_ni, cfg_clear, valid_q == '0 && !res_valid_o, "table not cleared by config write")

endmodule
